@@ hdl/spq_pkg.sv @@
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int PRIO_W   = 16;
    localparam int OCC_W    = 5;
    localparam int STAT_W   = 2;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_INSERTED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DEQUEUED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [PRIO_W-1:0] prio;
        logic signed [VAL_W-1:0]  value;
    } spq_ctrl_t;

endpackage

@@ hdl/stable_priority_queue.sv @@
// Stable priority queue of spq_pkg::CAPACITY entries, kept sorted highest
// priority first in a row of cells; equal priorities leave in arrival order.
// In every transaction (enqueue or dequeue) all cells compare against the
// new priority in parallel and shift by one place in the same edge, so a
// new transaction is accepted each cycle while the registered
// result is taken. Each transaction yields one result: status, the dequeued
// value (zero otherwise) and the occupancy after the transaction. An enqueue
// when full is dropped with the full status; a dequeue when empty reports
// underflow. No clearing pass is needed after reset.
module stable_priority_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [spq_pkg::VAL_W-1:0]    item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic        [spq_pkg::STAT_W-1:0]   status,
    output logic signed [spq_pkg::VAL_W-1:0]    out_value,
    output logic        [spq_pkg::OCC_W-1:0]    occupancy
);

    localparam int N = spq_pkg::CAPACITY;

    logic                              accept;
    logic                              is_full;
    logic                              is_empty;
    spq_pkg::spq_ctrl_t                ctrl;
    logic [N-1:0]                      live;
    logic [N-1:0]                      ge;
    logic signed [spq_pkg::VAL_W-1:0]  cell_value [N];
    logic signed [spq_pkg::PRIO_W-1:0] cell_prio  [N];

    logic [spq_pkg::CNT_W-1:0]          count_reg;
    logic [spq_pkg::CNT_W-1:0]          count_next;
    logic                               out_valid_reg;
    logic [spq_pkg::STAT_W-1:0]         status_reg;
    logic [spq_pkg::STAT_W-1:0]         status_next;
    logic signed [spq_pkg::VAL_W-1:0]   out_value_reg;
    logic signed [spq_pkg::VAL_W-1:0]   out_value_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = count_reg == spq_pkg::CNT_W'(N);
    assign is_empty = count_reg == '0;

    assign ctrl.enq   = accept && (action == spq_pkg::ACT_ENQUEUE) && !is_full;
    assign ctrl.deq   = accept && (action == spq_pkg::ACT_DEQUEUE) && !is_empty;
    assign ctrl.prio  = item_priority;
    assign ctrl.value = item_value;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            logic                              left_ge;
            logic signed [spq_pkg::VAL_W-1:0]  left_value;
            logic signed [spq_pkg::PRIO_W-1:0] left_prio;
            logic signed [spq_pkg::VAL_W-1:0]  right_value;
            logic signed [spq_pkg::PRIO_W-1:0] right_prio;

            assign live[i] = count_reg > spq_pkg::CNT_W'(i);

            if (i == 0)
            begin : g_head
                assign left_ge    = 1'b1;
                assign left_value = item_value;
                assign left_prio  = item_priority;
            end
            else
            begin : g_body
                assign left_ge    = ge[i-1];
                assign left_value = cell_value[i-1];
                assign left_prio  = cell_prio[i-1];
            end

            if (i == N - 1)
            begin : g_tail
                assign right_value = cell_value[i];
                assign right_prio  = cell_prio[i];
            end
            else
            begin : g_inner
                assign right_value = cell_value[i+1];
                assign right_prio  = cell_prio[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .live        (live[i]),
                .left_ge     (left_ge),
                .left_value  (left_value),
                .left_prio   (left_prio),
                .right_value (right_value),
                .right_prio  (right_prio),
                .ge          (ge[i]),
                .value       (cell_value[i]),
                .prio        (cell_prio[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        status_next    = spq_pkg::STAT_INSERTED;
        out_value_next = '0;
        if (action == spq_pkg::ACT_ENQUEUE)
        begin
            if (is_full)
            begin
                status_next = spq_pkg::STAT_FULL;
            end
            else
            begin
                status_next = spq_pkg::STAT_INSERTED;
                count_next  = count_reg + spq_pkg::CNT_W'(1);
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = spq_pkg::STAT_UNDERFLOW;
            end
            else
            begin
                status_next    = spq_pkg::STAT_DEQUEUED;
                out_value_next = cell_value[0];
                count_next     = count_reg - spq_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_value = out_value_reg;
    assign occupancy = spq_pkg::OCC_W'(count_reg);

endmodule

@@ hdl/spq_cell.sv @@
module spq_cell (
    input  logic                              clk,
    input  spq_pkg::spq_ctrl_t                ctrl,
    input  logic                              live,
    input  logic                              left_ge,
    input  logic signed [spq_pkg::VAL_W-1:0]  left_value,
    input  logic signed [spq_pkg::PRIO_W-1:0] left_prio,
    input  logic signed [spq_pkg::VAL_W-1:0]  right_value,
    input  logic signed [spq_pkg::PRIO_W-1:0] right_prio,
    output logic                              ge,
    output logic signed [spq_pkg::VAL_W-1:0]  value,
    output logic signed [spq_pkg::PRIO_W-1:0] prio
);

    logic signed [spq_pkg::VAL_W-1:0]  value_reg;
    logic signed [spq_pkg::VAL_W-1:0]  value_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0] prio_next;

    assign ge    = live && (prio_reg >= ctrl.prio);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.enq && !ge)
        begin
            if (left_ge)
            begin
                value_next = ctrl.value;
                prio_next  = ctrl.prio;
            end
            else
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end
        else if (ctrl.deq)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [spq_pkg::STAT_W-1:0]       status;
        logic signed [spq_pkg::VAL_W-1:0] value;
        logic [spq_pkg::OCC_W-1:0]        occ;
    } qresult_t;

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               in_valid      = 1'b0;
    logic                               in_ready;
    logic                               action        = spq_pkg::ACT_ENQUEUE;
    logic signed [spq_pkg::VAL_W-1:0]   item_value    = '0;
    logic signed [spq_pkg::PRIO_W-1:0]  item_priority = '0;
    logic                               out_valid;
    logic                               out_ready     = 1'b0;
    logic [spq_pkg::STAT_W-1:0]         status;
    logic signed [spq_pkg::VAL_W-1:0]   out_value;
    logic [spq_pkg::OCC_W-1:0]          occupancy;

    logic signed [spq_pkg::VAL_W-1:0]   model_value [spq_pkg::CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0]  model_prio  [spq_pkg::CAPACITY];
    int                                 model_count = 0;

    qresult_t                  pending_results [$];
    qresult_t                  want_res;
    int                        errors     = 0;
    int                        quiet      = 0;
    bit                        hold_req   = 1'b0;
    int                        hold_len   = 0;
    bit                        gaps_on    = 1'b1;
    int                        burst_left = 0;

    stable_priority_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_value     (out_value),
        .occupancy     (occupancy)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic qresult_t queue_step(input logic act,
                                            input logic signed [spq_pkg::VAL_W-1:0] v,
                                            input logic signed [spq_pkg::PRIO_W-1:0] p);
        qresult_t r;
        int       pos;
        r.value = '0;
        if (act == spq_pkg::ACT_ENQUEUE)
        begin
            if (model_count >= spq_pkg::CAPACITY)
            begin
                r.status = spq_pkg::STAT_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < model_count && model_prio[pos] >= p)
                    pos++;
                for (int i = model_count; i > pos; i--)
                begin
                    model_value[i] = model_value[i-1];
                    model_prio[i]  = model_prio[i-1];
                end
                model_value[pos] = v;
                model_prio[pos]  = p;
                model_count++;
                r.status = spq_pkg::STAT_INSERTED;
            end
        end
        else if (model_count == 0)
        begin
            r.status = spq_pkg::STAT_UNDERFLOW;
        end
        else
        begin
            r.value = model_value[0];
            for (int i = 1; i < model_count; i++)
            begin
                model_value[i-1] = model_value[i];
                model_prio[i-1]  = model_prio[i];
            end
            model_count--;
            r.status = spq_pkg::STAT_DEQUEUED;
        end
        r.occ = spq_pkg::OCC_W'(model_count);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            pending_results.push_back(queue_step(action, item_value, item_priority));
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction pending: status %0d value %0d occupancy %0d",
                       status, out_value, occupancy);
                errors++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (status !== want_res.status)
                begin
                    $error("status: expected %0d, actual %0d", want_res.status, status);
                    errors++;
                end
                if (out_value !== want_res.value)
                begin
                    $error("out_value: expected %0d, actual %0d", want_res.value, out_value);
                    errors++;
                end
                if (occupancy !== want_res.occ)
                begin
                    $error("occupancy: expected %0d, actual %0d", want_res.occ, occupancy);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("stable_priority_queue verification failed");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int mode_left;
        int cyc;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 4);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 1) != 0);
                    3:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic act,
                             input logic signed [spq_pkg::VAL_W-1:0] v,
                             input logic signed [spq_pkg::PRIO_W-1:0] p);
        int gap;
        in_valid      <= 1'b1;
        action        <= act;
        item_value    <= v;
        item_priority <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (gaps_on)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                gap = $urandom_range(1, 10);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(0, 30);
            end
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_underflow();
        send_item(spq_pkg::ACT_DEQUEUE, 32'sh7FFF_FFFF, 16'sh7FFF);
        send_item(spq_pkg::ACT_DEQUEUE, 32'sh8000_0000, 16'sh8000);
    endtask

    task automatic test_fill_and_reject();
        logic signed [spq_pkg::PRIO_W-1:0] prios [16];
        logic signed [spq_pkg::VAL_W-1:0]  v;
        prios = '{16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1, 16'sh7FFF, 16'sd1,
                  16'sh8000, 16'sd0, 16'sd5, 16'sd5, -16'sd1, 16'sd1, 16'sd5, 16'sd0};
        for (int i = 0; i < spq_pkg::CAPACITY; i++)
        begin
            case (i)
                0:       v = 32'sh7FFF_FFFF;
                1:       v = 32'sh8000_0000;
                2:       v = '0;
                3:       v = -32'sd1;
                default: v = 32'(100 + i);
            endcase
            send_item(spq_pkg::ACT_ENQUEUE, v, prios[i % 16]);
        end
        send_item(spq_pkg::ACT_ENQUEUE, 32'sd555, 16'sh7FFF);
    endtask

    task automatic test_partial_drain();
        for (int i = 0; i < 4; i++)
            send_item(spq_pkg::ACT_DEQUEUE, $urandom, spq_pkg::PRIO_W'($urandom));
    endtask

    task automatic test_random(input int count);
        int                                enq_pct;
        int                                phase_left;
        int                                sel;
        logic                              act;
        logic signed [spq_pkg::VAL_W-1:0]  v;
        logic signed [spq_pkg::PRIO_W-1:0] p;
        enq_pct    = 50;
        phase_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (phase_left == 0)
            begin
                sel        = $urandom_range(0, 2);
                enq_pct    = (sel == 0) ? 25 : (sel == 1) ? 50 : 80;
                phase_left = $urandom_range(10, 50);
            end
            phase_left--;
            act = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::ACT_ENQUEUE
                                                     : spq_pkg::ACT_DEQUEUE;
            sel = $urandom_range(0, 9);
            if (sel < 6)
                p = spq_pkg::PRIO_W'(int'($urandom_range(0, 6)) - 3);
            else if (sel < 9)
                p = spq_pkg::PRIO_W'($urandom);
            else
                p = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            sel = $urandom_range(0, 15);
            if (sel == 0)
                v = 32'sh7FFF_FFFF;
            else if (sel == 1)
                v = 32'sh8000_0000;
            else
                v = $urandom;
            send_item(act, v, p);
        end
    endtask

    task automatic test_backpressure();
        logic act;
        gaps_on  = 1'b0;
        hold_len = 80;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            act = ($urandom_range(0, 9) < 6) ? spq_pkg::ACT_ENQUEUE : spq_pkg::ACT_DEQUEUE;
            send_item(act, $urandom, spq_pkg::PRIO_W'($urandom));
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        wait_for_results();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_underflow();
        test_fill_and_reject();
        test_partial_drain();
        test_random(500);
        test_backpressure();
        test_sender_pause();
        test_random(500);
        wait_for_results();
        if (errors == 0 && pending_results.size() == 0)
            $display("stable_priority_queue verification clean");
        else
            $display("stable_priority_queue verification failed");
        $finish;
    end

endmodule

@@ stable_priority_queue.f @@
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue.sv
dv/tb.sv
